### rtl/i2c_master_event_sequencer_unit_defines.svh
// Assertion macros shared by the checker of the I2C master event sequencer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef I2C_MASTER_EVENT_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_EVENT_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define I2CMES_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define I2CMES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/i2cmes_pkg.sv
// Package of the I2C master event sequencer: codes, constants, word structs.
// No dependencies; imported by all sequencer modules.
package i2cmes_pkg;

  localparam int LENGTH_WIDTH_DEF = 16;

  // Field widths fixed by the interface
  localparam int LEN_FIELD_W = 16;
  localparam int FLAGS_CLR_W = 3;

  // Direction bit and address mask for the address byte
  localparam logic       DIR_READ       = 1'b1;
  localparam logic       DIR_WRITE      = 1'b0;
  localparam logic [7:0] ADDR_KEEP_MASK = 8'hFE;

  // Bit positions in flags_clear
  localparam int FC_AF   = 0;
  localparam int FC_BERR = 1;
  localparam int FC_ARLO = 2;

  typedef enum logic [1:0] {
    OP_START_WR  = 2'd0,
    OP_START_RD  = 2'd1,
    OP_BUS_EVENT = 2'd2,
    OP_ERR_EVENT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARAM = 2'd1,
    ST_BUSY  = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_READY   = 2'd1,
    MODE_BUSY_TX = 2'd2,
    MODE_BUSY_RX = 2'd3
  } mode_t;

  typedef struct packed {
    op_t                    operation;
    logic [7:0]             dev_address;
    logic [LEN_FIELD_W-1:0] length;
    logic                   flag_sb;
    logic                   flag_addr;
    logic                   flag_txe;
    logic                   flag_rxne;
    logic                   flag_af;
    logic                   flag_berr;
    logic                   flag_arlo;
    logic [7:0]             tx_byte;
    logic [7:0]             rx_data;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic                   data_write;
    logic [7:0]             data_value;
    logic                   rx_valid;
    logic [7:0]             rx_byte;
    logic                   ack_clear;
    logic                   stop_request;
    logic                   start_request;
    logic [FLAGS_CLR_W-1:0] flags_clear;
    logic                   tx_done;
    logic                   rx_done;
    logic                   error_done;
  } out_item_t;

  // Pipeline control between the input stage, core and result stage
  typedef struct packed {
    logic s1_valid;
    logic advance;
  } pipe_ctl_t;

endpackage

### rtl/i2cmes_cmd_if.sv
// Command channel of the I2C master event sequencer: valid/ready plus item fields.
// No dependencies.
interface i2cmes_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  dev_address;
  logic [15:0] length;
  logic        flag_sb;
  logic        flag_addr;
  logic        flag_txe;
  logic        flag_rxne;
  logic        flag_af;
  logic        flag_berr;
  logic        flag_arlo;
  logic [7:0]  tx_byte;
  logic [7:0]  rx_data;

  modport source (
    output valid, operation, dev_address, length, flag_sb, flag_addr, flag_txe,
           flag_rxne, flag_af, flag_berr, flag_arlo, tx_byte, rx_data,
    input  ready
  );
  modport sink (
    input  valid, operation, dev_address, length, flag_sb, flag_addr, flag_txe,
           flag_rxne, flag_af, flag_berr, flag_arlo, tx_byte, rx_data,
    output ready
  );
  modport monitor (
    input valid, ready, operation, dev_address, length, flag_sb, flag_addr,
          flag_txe, flag_rxne, flag_af, flag_berr, flag_arlo, tx_byte, rx_data
  );
endinterface

### rtl/i2cmes_rsp_if.sv
// Result channel of the I2C master event sequencer: valid/ready plus result fields.
// No dependencies.
interface i2cmes_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       data_write;
  logic [7:0] data_value;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       ack_clear;
  logic       stop_request;
  logic       start_request;
  logic [2:0] flags_clear;
  logic       tx_done;
  logic       rx_done;
  logic       error_done;

  modport source (
    output valid, status, data_write, data_value, rx_valid, rx_byte, ack_clear,
           stop_request, start_request, flags_clear, tx_done, rx_done, error_done,
    input  ready
  );
  modport sink (
    input  valid, status, data_write, data_value, rx_valid, rx_byte, ack_clear,
           stop_request, start_request, flags_clear, tx_done, rx_done, error_done,
    output ready
  );
  modport monitor (
    input valid, ready, status, data_write, data_value, rx_valid, rx_byte,
          ack_clear, stop_request, start_request, flags_clear, tx_done, rx_done,
          error_done
  );
endinterface

### rtl/i2cmes_in_stage.sv
// Input register of the sequencer: captures one command word per cycle unless stalled.
// Depends on i2cmes_pkg and i2cmes_cmd_if.
module i2cmes_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  i2cmes_cmd_if.sink           cmd,
  input  logic                 advance,
  output logic                 s1_valid,
  output i2cmes_pkg::in_item_t item
);
  import i2cmes_pkg::*;

  logic take;

  // Stage is free when empty or when its word moves on this cycle
  assign cmd.ready = !s1_valid || advance;
  assign take      = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      item.operation   <= op_t'(cmd.operation);
      item.dev_address <= cmd.dev_address;
      item.length      <= cmd.length;
      item.flag_sb     <= cmd.flag_sb;
      item.flag_addr   <= cmd.flag_addr;
      item.flag_txe    <= cmd.flag_txe;
      item.flag_rxne   <= cmd.flag_rxne;
      item.flag_af     <= cmd.flag_af;
      item.flag_berr   <= cmd.flag_berr;
      item.flag_arlo   <= cmd.flag_arlo;
      item.tx_byte     <= cmd.tx_byte;
      item.rx_data     <= cmd.rx_data;
    end
  end
endmodule

### rtl/i2cmes_core.sv
// Transfer state and single-pass decode of one command word into one result.
// Depends on i2cmes_pkg.
module i2cmes_core #(
  parameter int LENGTH_WIDTH = i2cmes_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  i2cmes_pkg::pipe_ctl_t ctl,
  input  i2cmes_pkg::in_item_t  item,
  output i2cmes_pkg::out_item_t result
);
  import i2cmes_pkg::*;

  mode_t                   mode, mode_next;
  logic                    events_enabled, events_enabled_next;
  logic [7:0]              target_address, target_address_next;
  logic [LENGTH_WIDTH-1:0] tx_remaining, tx_remaining_next;
  logic [LENGTH_WIDTH-1:0] rx_remaining, rx_remaining_next;

  logic [LENGTH_WIDTH-1:0] len_red;
  logic                    is_start, len_zero, tx_left, rx_left, rx_last;
  logic                    commit;

  // Length reduced to the counter width
  assign len_red  = LENGTH_WIDTH'(item.length);
  assign len_zero = (len_red == '0);
  assign is_start = (item.operation == OP_START_WR) || (item.operation == OP_START_RD);
  assign tx_left  = (tx_remaining != '0);
  assign rx_left  = (rx_remaining != '0);
  assign rx_last  = (rx_remaining == LENGTH_WIDTH'(1));
  assign commit   = ctl.s1_valid && ctl.advance;

  // Next-state logic
  always_comb begin
    mode_next           = mode;
    events_enabled_next = events_enabled;
    target_address_next = target_address;
    tx_remaining_next   = tx_remaining;
    rx_remaining_next   = rx_remaining;
    if (is_start) begin
      if (!len_zero && mode == MODE_READY) begin
        target_address_next = item.dev_address;
        events_enabled_next = 1'b1;
        if (item.operation == OP_START_WR) begin
          mode_next         = MODE_BUSY_TX;
          tx_remaining_next = len_red;
        end else begin
          mode_next         = MODE_BUSY_RX;
          rx_remaining_next = len_red;
        end
      end
    end else if (events_enabled) begin
      if (item.operation == OP_BUS_EVENT) begin
        priority if (item.flag_sb || item.flag_addr) begin
          // address phase: no state change
        end else if (item.flag_txe) begin
          if (tx_left) begin
            tx_remaining_next = tx_remaining - LENGTH_WIDTH'(1);
          end else begin
            events_enabled_next = 1'b0;
            mode_next           = MODE_READY;
          end
        end else if (item.flag_rxne && rx_left) begin
          rx_remaining_next = rx_remaining - LENGTH_WIDTH'(1);
          if (rx_last) begin
            events_enabled_next = 1'b0;
            mode_next           = MODE_READY;
          end
        end else begin
          // nothing to serve
        end
      end else begin
        // error event: abandon transfer, events stay enabled
        mode_next = MODE_READY;
      end
    end
  end

  // Result logic
  always_comb begin
    result        = '0;
    result.status = ST_NONE;
    if (is_start) begin
      priority if (len_zero) begin
        result.status = ST_PARAM;
      end else if (mode != MODE_READY) begin
        result.status = ST_BUSY;
      end else begin
        result.status        = ST_OK;
        result.start_request = 1'b1;
      end
    end else if (events_enabled) begin
      if (item.operation == OP_BUS_EVENT) begin
        priority if (item.flag_sb) begin
          result.data_write = 1'b1;
          result.data_value = (target_address & ADDR_KEEP_MASK) |
                              {7'd0, (mode == MODE_BUSY_RX) ? DIR_READ : DIR_WRITE};
        end else if (item.flag_addr) begin
          result.ack_clear = (mode == MODE_BUSY_RX) && rx_last;
        end else if (item.flag_txe) begin
          if (tx_left) begin
            result.data_write = 1'b1;
            result.data_value = item.tx_byte;
          end else begin
            result.stop_request = 1'b1;
            result.tx_done      = 1'b1;
          end
        end else if (item.flag_rxne && rx_left) begin
          result.rx_valid     = 1'b1;
          result.rx_byte      = item.rx_data;
          result.ack_clear    = rx_last;
          result.stop_request = rx_last;
          result.rx_done      = rx_last;
        end else begin
          // nothing to serve
        end
      end else begin
        result.flags_clear[FC_AF]   = item.flag_af;
        result.flags_clear[FC_BERR] = item.flag_berr;
        result.flags_clear[FC_ARLO] = item.flag_arlo;
        result.stop_request         = item.flag_af;
        result.error_done           = 1'b1;
      end
    end
  end

  // State registers, updated when a word leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_READY;
      events_enabled <= 1'b0;
      target_address <= '0;
      tx_remaining   <= '0;
      rx_remaining   <= '0;
    end else if (commit) begin
      mode           <= mode_next;
      events_enabled <= events_enabled_next;
      target_address <= target_address_next;
      tx_remaining   <= tx_remaining_next;
      rx_remaining   <= rx_remaining_next;
    end
  end
endmodule

### rtl/i2cmes_out_stage.sv
// Result register of the sequencer: holds one result word until taken.
// Depends on i2cmes_pkg and i2cmes_rsp_if.
module i2cmes_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s1_valid,
  input  i2cmes_pkg::out_item_t result,
  output logic                  advance,
  i2cmes_rsp_if.source          rsp
);
  import i2cmes_pkg::*;

  out_item_t held;

  // Register can load when empty or being drained this cycle
  assign advance = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      held <= result;
    end
  end

  assign rsp.status        = held.status;
  assign rsp.data_write    = held.data_write;
  assign rsp.data_value    = held.data_value;
  assign rsp.rx_valid      = held.rx_valid;
  assign rsp.rx_byte       = held.rx_byte;
  assign rsp.ack_clear     = held.ack_clear;
  assign rsp.stop_request  = held.stop_request;
  assign rsp.start_request = held.start_request;
  assign rsp.flags_clear   = held.flags_clear;
  assign rsp.tx_done       = held.tx_done;
  assign rsp.rx_done       = held.rx_done;
  assign rsp.error_done    = held.error_done;
endmodule

### rtl/i2c_master_event_sequencer_unit.sv
// Interrupt-driven I2C master event sequencer, top level.
// Depends on i2cmes_pkg, i2cmes_cmd_if, i2cmes_rsp_if and the three stage modules.
//
// Every command word (start write, start read, bus event or error event) yields
// exactly one result word. The block takes one word per clock while the result
// side does not stall: a word is held in the input register, is decoded against
// the transfer state in a single pass and lands in the result register. The
// throughput of one word per cycle is set by the transfer-state update, which
// commits in the same cycle the word moves to the result register; stalls on
// the result side back up through both registers. The byte counters are
// LENGTH_WIDTH bits wide and the length field is reduced to that width before
// the zero check.
module i2c_master_event_sequencer_unit #(
  parameter int LENGTH_WIDTH = i2cmes_pkg::LENGTH_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  i2cmes_cmd_if.sink   cmd,
  i2cmes_rsp_if.source rsp
);
  import i2cmes_pkg::*;

  in_item_t  item;
  out_item_t result;
  pipe_ctl_t ctl;
  logic      s1_valid;
  logic      advance;

  assign ctl.s1_valid = s1_valid;
  assign ctl.advance  = advance;

  i2cmes_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .advance  (advance),
    .s1_valid (s1_valid),
    .item     (item)
  );

  i2cmes_core #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (item),
    .result (result)
  );

  i2cmes_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .result   (result),
    .advance  (advance),
    .rsp      (rsp)
  );
endmodule

### rtl/i2cmes_checker.sv
// Port-level checker for the I2C master event sequencer, bound to the top level.
// Depends on i2cmes_pkg, the result channel interface and the assertion macro header.
`include "i2c_master_event_sequencer_unit_defines.svh"

module i2cmes_checker (
  input logic          clk,
  input logic          rst,
  i2cmes_rsp_if.source rsp
);
  import i2cmes_pkg::*;

  // A stalled result word holds
  `I2CMES_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp.valid && !rsp.ready,
    rsp.valid && $stable(rsp.status) && $stable(rsp.data_value) && $stable(rsp.rx_byte),
    "result word changed while stalled")

  // No result word right after reset
  `I2CMES_ASSERT_NOW(a_rsp_reset, clk, rst, $past(rst), !rsp.valid,
    "result valid right after reset")

  // Start status words carry no bus actions
  `I2CMES_ASSERT_NOW(a_start_clean, clk, rst, rsp.valid && (rsp.status != ST_NONE),
    !rsp.data_write && !rsp.rx_valid && !rsp.stop_request && (rsp.flags_clear == 3'd0) &&
    (rsp.start_request == (rsp.status == ST_OK)), "start result carries bus actions")

  // Completions are exclusive and come from event words only
  `I2CMES_ASSERT_NOW(a_done_excl, clk, rst,
    rsp.valid && (rsp.tx_done || rsp.rx_done || rsp.error_done),
    $onehot({rsp.tx_done, rsp.rx_done, rsp.error_done}) && (rsp.status == ST_NONE) &&
    !rsp.start_request, "completion flags inconsistent")

endmodule

bind i2c_master_event_sequencer_unit i2cmes_checker u_chk (
  .clk (clk),
  .rst (rst),
  .rsp (rsp)
);
